// ----- hw/rtl/scanline_sky_gradient_assert.svh -----
// Assertion macros used by the backdrop colour generator RTL.
`ifndef SCANLINE_SKY_GRADIENT_ASSERT_SVH
`define SCANLINE_SKY_GRADIENT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ssg_pkg.sv -----
// Package with constants, types and the colour ramp for the backdrop generator.
`default_nettype none
package ssg_pkg;

  localparam int HORIZON_MAX    = 160;
  localparam int SCREEN_LINES   = 224;
  localparam int RAMP_ENTRIES   = 384;
  localparam int BAND_HEIGHT    = 40;
  localparam int BOTTOM_EXTRA   = 8;
  localparam int FIRST_IRQ_LINE = 32;

  localparam int RAMP_AW   = $clog2(RAMP_ENTRIES);
  localparam int CALC_W    = 12;
  localparam int KEY_LAST  = 40;
  localparam int LUT_DEPTH = KEY_LAST + 1;
  localparam int LUT_AW    = $clog2(LUT_DEPTH);

  localparam logic [7:0] HORIZON_SAT = 8'(HORIZON_MAX);

  typedef logic [11:0] color_t;
  typedef logic signed [CALC_W-1:0] calc_t;

  localparam calc_t RAMP_LIMIT   = calc_t'(RAMP_ENTRIES - HORIZON_MAX - 1);
  localparam calc_t SCREEN_LIMIT = calc_t'(SCREEN_LINES - 1);

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_LINE  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_ENABLE  = 1'b0,
    REG_HORIZON = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TOP,
    KIND_RAMP
  } kind_t;

  typedef struct packed {
    logic                 we;
    logic [RAMP_AW-1:0]   addr;
    color_t               data;
  } fill_wr_t;

  // 3-bit red, green, blue per distance 0..40
  localparam logic [8:0] RAMP_LUT [LUT_DEPTH] = '{
    9'o365, 9'o365, 9'o465, 9'o465, 9'o465, 9'o465, 9'o566, 9'o566,
    9'o566, 9'o566, 9'o566, 9'o566, 9'o566, 9'o666, 9'o666, 9'o666,
    9'o656, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657,
    9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657,
    9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o657, 9'o547,
    9'o547
  };

  function automatic color_t pack_rgb(input logic [8:0] rgb);
    return {rgb[2:0], 1'b0, rgb[5:3], 1'b0, rgb[8:6], 1'b0};
  endfunction

  function automatic color_t dist_color(input calc_t d);
    color_t c;
    if (d <= 0) begin
      c = pack_rgb(RAMP_LUT[0]);
    end else if (d >= calc_t'(KEY_LAST)) begin
      c = pack_rgb(RAMP_LUT[KEY_LAST]);
    end else begin
      c = pack_rgb(RAMP_LUT[d[LUT_AW-1:0]]);
    end
    return c;
  endfunction

  localparam color_t TOP_COLOR = pack_rgb(RAMP_LUT[KEY_LAST]);

endpackage
`default_nettype wire

// ----- hw/rtl/scanline_sky_gradient.sv -----
// Top level of the backdrop colour generator.
// Usage:
//   Input channel (in_valid/in_stall, opcode, line): a frame start or a
//   scanline event. Output channel (out_valid/out_stall, write_enable,
//   color): exactly one result per request, in request order.
//   Configuration: cfg_write with cfg_index/cfg_data writes enable or the
//   horizon line (saturated to HORIZON_MAX); write only while idle.
// Pipeline: a request accepted at a clock edge is read from the ramp memory at
//   that edge into the read stage; the output register loads from the read
//   stage when it is empty or its result is not stalled.
// Throughput: one request per cycle while in_stall is low; the ramp memory has
//   one read port and each request reads it once.
// Reset: a sweep over all RAMP_ENTRIES entries loads the colour ramp memory;
//   in_stall stays high until it ends, configuration writes are taken throughout.
// Stall: a stalled result holds in the output register; the next request
//   still enters the read stage, and in_stall rises when both stages are full
//   and out_stall is high, and throughout the fill sweep.
`default_nettype none
module scanline_sky_gradient import ssg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        opcode,
  input  wire logic [7:0]  line,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        write_enable,
  output      color_t      color
);

  logic               enable;
  logic [7:0]         horizon;
  logic               fill_busy;
  fill_wr_t           fill_wr;
  logic               accept;
  logic               v1;
  kind_t              kind1;
  kind_t              kind_next;
  logic [RAMP_AW-1:0] raddr;
  color_t             rdata;
  logic               advance1;
  color_t             color_next;

  ssg_fill u_fill (
    .clk  (clk),
    .rst  (rst),
    .busy (fill_busy),
    .wr   (fill_wr)
  );

  ssg_ram #(
    .WIDTH ($bits(color_t)),
    .DEPTH (RAMP_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (fill_wr.we),
    .waddr (fill_wr.addr),
    .wdata (fill_wr.data),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b1;
      horizon <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_ENABLE:  enable  <= cfg_data[0];
        REG_HORIZON: horizon <= (cfg_data > HORIZON_SAT) ? HORIZON_SAT : cfg_data;
      endcase
    end
  end

  always_comb begin
    calc_t hs;
    calc_t ys;
    calc_t start;
    calc_t bottom;
    calc_t restore;
    calc_t offset;
    hs      = calc_t'(horizon);
    ys      = calc_t'(line);
    start   = hs - calc_t'(BAND_HEIGHT);
    if (start < 0) begin
      start = '0;
    end
    bottom  = hs + calc_t'(BOTTOM_EXTRA);
    if (bottom > RAMP_LIMIT) begin
      bottom = RAMP_LIMIT;
    end
    if (bottom > SCREEN_LIMIT) begin
      bottom = SCREEN_LIMIT;
    end
    restore = bottom + calc_t'(1);
    offset  = calc_t'(HORIZON_MAX) + ys - hs;
    raddr   = offset[RAMP_AW-1:0];
    if (opcode_t'(opcode) == OP_FRAME) begin
      kind_next = KIND_TOP;
    end else if (!enable) begin
      kind_next = KIND_NONE;
    end else if (ys >= start && ys <= bottom) begin
      kind_next = KIND_RAMP;
    end else if (ys == restore && restore >= 0 && restore <= SCREEN_LIMIT) begin
      kind_next = KIND_TOP;
    end else begin
      kind_next = KIND_NONE;
    end
  end

  assign advance1 = v1 && (!out_valid || !out_stall);
  assign in_stall = fill_busy || (v1 && out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (advance1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind1 <= kind_next;
    end
  end

  always_comb begin
    case (kind1)
      KIND_RAMP: color_next = rdata;
      KIND_TOP:  color_next = TOP_COLOR;
      default:   color_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance1) begin
      write_enable <= (kind1 != KIND_NONE);
      color        <= color_next;
    end
  end

`include "scanline_sky_gradient_assert.svh"

  `SSG_ASSERT_IMP(a_no_accept_fill, clk, rst, fill_busy, !accept, "request accepted during fill")
  `SSG_ASSERT_NXT(a_accept_loads, clk, rst, accept, v1, "accepted request lost")
  `SSG_ASSERT_NXT(a_stage_hold, clk, rst, v1 && !advance1, v1 && $stable(kind1), "read stage moved")
  `SSG_ASSERT_IMP(a_idle_color, clk, rst, out_valid && !write_enable, color == '0, "nonzero idle color")

endmodule
`default_nettype wire

// ----- hw/rtl/ssg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssg_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ssg_fill.sv -----
// Post-reset sweep that loads the colour ramp memory, one entry per cycle.
`default_nettype none
module ssg_fill import ssg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  output      logic busy,
  output      fill_wr_t wr
);

  logic [RAMP_AW-1:0] cnt;
  calc_t              distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == RAMP_AW'(RAMP_ENTRIES - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    distance = calc_t'(HORIZON_MAX) - calc_t'(cnt);
    wr.we    = busy;
    wr.addr  = cnt;
    wr.data  = dist_color(distance);
  end

endmodule
`default_nettype wire

// ----- sim/scanline_sky_gradient_test.sv -----
// Self-checking testbench for the scanline backdrop colour generator.
`timescale 1ns / 100ps

module scanline_sky_gradient_test;
  import ssg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 100;

  typedef struct {
    logic   we;
    color_t color;
  } backdrop_write_t;

  class sky_scoreboard;
    int key_dist[5] = '{0, 6, 14, 26, 40};
    int key_r[5]    = '{110, 165, 200, 198, 190};
    int key_g[5]    = '{200, 205, 195, 170, 158};
    int key_b[5]    = '{175, 195, 220, 238, 242};

    logic            enabled;
    logic [7:0]      horizon;
    backdrop_write_t writes_due[$];
    int              failures;
    int              checked;
    int              frames;
    int              ramp_writes;
    int              restores;
    int              quiet_lines;

    function new();
      enabled = 1'b1;
      horizon = 8'd0;
    endfunction

    function void write_reg(reg_index_t idx, logic [7:0] value);
      if (idx == REG_ENABLE) begin
        enabled = value[0];
      end else begin
        horizon = (value > HORIZON_MAX) ? 8'(HORIZON_MAX) : value;
      end
    endfunction

    function int band_top();
      int t;
      t = int'(horizon) - BAND_HEIGHT;
      return (t < 0) ? 0 : t;
    endfunction

    function int band_bottom();
      int b;
      b = int'(horizon) + BOTTOM_EXTRA;
      if (b > RAMP_ENTRIES - HORIZON_MAX - 1) b = RAMP_ENTRIES - HORIZON_MAX - 1;
      if (b > SCREEN_LINES - 1) b = SCREEN_LINES - 1;
      return b;
    endfunction

    function color_t shade(int d);
      int i;
      int r;
      int g;
      int b;
      logic [7:0] r8;
      logic [7:0] g8;
      logic [7:0] b8;
      color_t c;
      if (d <= key_dist[0]) begin
        r = key_r[0]; g = key_g[0]; b = key_b[0];
      end else if (d >= key_dist[4]) begin
        r = key_r[4]; g = key_g[4]; b = key_b[4];
      end else begin
        i = 0;
        while (d > key_dist[i+1]) i++;
        r = key_r[i] + ((key_r[i+1] - key_r[i]) * (d - key_dist[i])) /
            (key_dist[i+1] - key_dist[i]);
        g = key_g[i] + ((key_g[i+1] - key_g[i]) * (d - key_dist[i])) /
            (key_dist[i+1] - key_dist[i]);
        b = key_b[i] + ((key_b[i+1] - key_b[i]) * (d - key_dist[i])) /
            (key_dist[i+1] - key_dist[i]);
      end
      r8 = 8'(r);
      g8 = 8'(g);
      b8 = 8'(b);
      c = '0;
      c[3:1]  = r8[7:5];
      c[7:5]  = g8[7:5];
      c[11:9] = b8[7:5];
      return c;
    endfunction

    function void note_request(opcode_t op, logic [7:0] ln);
      backdrop_write_t w;
      int y;
      w.we = 1'b0;
      w.color = '0;
      y = int'(ln);
      if (op == OP_FRAME) begin
        w.we = 1'b1;
        w.color = shade(HORIZON_MAX);
        frames++;
      end else if (enabled && y >= band_top() && y <= band_bottom()) begin
        w.we = 1'b1;
        w.color = shade(int'(horizon) - y);
        ramp_writes++;
      end else if (enabled && y == band_bottom() + 1 && band_bottom() + 1 < SCREEN_LINES) begin
        w.we = 1'b1;
        w.color = shade(HORIZON_MAX);
        restores++;
      end else begin
        quiet_lines++;
      end
      writes_due.push_back(w);
    endfunction

    function void check_result(logic we, color_t c);
      backdrop_write_t w;
      if (writes_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: we=%0b color=%03h", we, c);
        return;
      end
      w = writes_due.pop_front();
      checked++;
      if (we !== w.we || c !== w.color) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected we=%0b color=%03h, got we=%0b color=%03h",
                   w.we, w.color, we, c);
      end
    endfunction

    function int pending();
      return writes_due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  opcode_t    opcode;
  logic [7:0] line;
  logic       out_valid;
  logic       out_stall;
  logic       write_enable;
  color_t     color;

  sky_scoreboard sb;
  logic tx_calm;
  logic rx_calm;
  logic long_hold_req;
  int   idle_cycles;
  int   settings_used;

  scanline_sky_gradient i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .line         (line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .color        (color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(opcode_t op, logic [7:0] ln);
    opcode   <= op;
    line     <= ln;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(op, ln);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic set_config(logic en, logic [7:0] hz);
    cfg_write <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data  <= {7'd0, en};
    @(posedge clk);
    sb.write_reg(REG_ENABLE, {7'd0, en});
    cfg_index <= REG_HORIZON;
    cfg_data  <= hz;
    @(posedge clk);
    sb.write_reg(REG_HORIZON, hz);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random();
    int lo;
    int hi;
    if ($urandom_range(0, 99) < 15) begin
      send_request(OP_FRAME, 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 99) < 70) begin
      lo = sb.band_top() - 3;
      hi = sb.band_bottom() + 3;
      if (lo < 0) lo = 0;
      if (hi > SCREEN_LINES - 1) hi = SCREEN_LINES - 1;
      send_request(OP_LINE, 8'($urandom_range(lo, hi)));
    end else begin
      send_request(OP_LINE, 8'($urandom_range(0, SCREEN_LINES - 1)));
    end
  endtask

  initial begin
    int n;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (rx_calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(write_enable, color);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] hz;
    logic       en;
    sb = new();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    long_hold_req = 1'b0;
    idle_cycles = 0;
    settings_used = 0;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_data  <= 8'd0;
    in_valid  <= 1'b0;
    opcode    <= OP_FRAME;
    line      <= 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_FRAME, 8'hFF);
    send_request(OP_LINE, 8'd0);
    send_request(OP_LINE, 8'd8);
    send_request(OP_LINE, 8'd9);
    send_request(OP_LINE, 8'd10);
    drain();
    set_config(1'b1, 8'hFF);
    send_request(OP_LINE, 8'd119);
    send_request(OP_LINE, 8'd120);
    send_request(OP_LINE, 8'd134);
    send_request(OP_LINE, 8'd146);
    send_request(OP_LINE, 8'd152);
    send_request(OP_LINE, 8'd159);
    send_request(OP_LINE, 8'd160);
    send_request(OP_LINE, 8'd161);
    send_request(OP_LINE, 8'd168);
    send_request(OP_LINE, 8'd169);
    send_request(OP_LINE, 8'd170);
    send_request(OP_LINE, 8'd223);
    send_request(OP_FRAME, 8'd0);
    drain();
    set_config(1'b0, 8'd100);
    send_request(OP_LINE, 8'd60);
    send_request(OP_LINE, 8'd100);
    send_request(OP_LINE, 8'd109);
    send_request(OP_FRAME, 8'd37);
    drain();
    set_config(1'b1, 8'd40);
    send_request(OP_LINE, 8'd0);
    send_request(OP_LINE, 8'd40);
    send_request(OP_LINE, 8'd48);
    send_request(OP_LINE, 8'd49);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: hz = 8'd0;
        1: hz = 8'd160;
        2: hz = 8'd255;
        5: hz = 8'd200;
        6: hz = 8'd1;
        default: hz = 8'($urandom_range(0, 255));
      endcase
      en = (ph == 4 || ph == 7) ? 1'b0 : 1'b1;
      set_config(en, hz);
      tx_calm = (ph == 3 || ph == 6);
      rx_calm = (ph == 6);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 20) long_hold_req = 1'b1;
        if (ph == 5 && k == 50) drain();
        send_random();
        if (!tx_calm) pause_sender(gap_len());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d requests over %0d settings: %0d frame starts, %0d ramp writes,",
             sb.checked, settings_used, sb.frames, sb.ramp_writes);
    $display("%0d restore writes, %0d lines without a write; %0d failures",
             sb.restores, sb.quiet_lines, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
